// ===== rtl/core/fhm_pkg.sv =====
package fhm_pkg;

  // request opcodes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // response status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  // commands handed from front to back
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_RESULT = 2'd3;

  // murmur finalizer constants
  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int FMIX_SHIFT = 33;
  localparam int KEY_SHIFT  = 3;

  // load limit: insert refused once (count + 1) * LOAD_DEN >= slots * LOAD_NUM
  localparam int LOAD_NUM = 7;
  localparam int LOAD_DEN = 10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  status;
    logic [63:0] key;
    logic [63:0] value;
  } entry_t;

endpackage

// ===== rtl/core/fhm_if.sv =====
// request channel
interface fhm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] key;
  logic [63:0] new_value;

  modport source (output valid, opcode, key, new_value, input ready);
  modport sink   (input valid, opcode, key, new_value, output ready);
endinterface

// response channel
interface fhm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

// ===== rtl/core/forwarding_hash_map.sv =====
// channel  modport  fields                        transfer
// req      sink     opcode, key, new_value        valid && ready
// rsp      source   status, found_value           valid && ready
//
// lookup/insert with a non-zero key: hashing (one shared 32x32 multiplier, six
// partial products), push into the queue, then a probe slot by slot in the back
// part; hashing of the next request overlaps the probe of the current one
// clear: the back part sweeps every slot, one valid bit written per cycle
// after reset a clearing pass runs over every slot; req.ready stays low
// a two-entry queue and the response register let front and back stall apart
module forwarding_hash_map #(
  parameter int SLOTS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  fhm_req_if.sink   req,
  fhm_rsp_if.source rsp
);
  import fhm_pkg::*;

  localparam int AW = $clog2(SLOTS);

  entry_t        f_ent;
  logic [AW-1:0] f_home;
  logic          f_valid;
  logic          f_ready;
  entry_t        b_ent;
  logic [AW-1:0] b_home;
  logic          b_valid;
  logic          b_ready;
  logic          init_done;

  // front: accept, classify, hash
  fhm_front #(.AW(AW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .init_done  (init_done),
    .push_ent   (f_ent),
    .push_home  (f_home),
    .push_valid (f_valid),
    .push_ready (f_ready)
  );

  // queue between front and back
  fhm_queue #(.AW(AW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_ent   (f_ent),
    .push_home  (f_home),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_ent    (b_ent),
    .pop_home   (b_home),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  // back: probe, insert, clear, respond
  fhm_back #(.SLOTS(SLOTS), .AW(AW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_ent     (b_ent),
    .q_home    (b_home),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .init_done (init_done),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/core/fhm_hash.sv =====
module fhm_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output logic [63:0] hash
);
  import fhm_pkg::*;

  logic [63:0] h;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [63:0] mul_full;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] coef;
  logic [63:0] key_sh;
  logic [2:0]  step;
  logic        round;
  logic        busy;

  assign key_sh = key >> KEY_SHIFT;
  assign coef   = round ? FMIX_C2 : FMIX_C1;

  // operand select for the shared 32x32 multiplier
  always_comb begin
    mul_a = h[31:0];
    mul_b = coef[31:0];
    case (step)
      3'd1:    mul_b = coef[63:32];
      3'd2:    mul_a = h[63:32];
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // control: busy flag, step and round counters, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      step  <= 3'd0;
      round <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= !start && busy && (step == 3'd4) && round;
      if (start) begin
        busy  <= 1'b1;
        step  <= 3'd0;
        round <= 1'b0;
      end else if (busy) begin
        if (step == 3'd4) begin
          step <= 3'd0;
          if (round) begin
            busy <= 1'b0;
          end else begin
            round <= 1'b1;
          end
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  // datapath: low 64 bits of h * coef from three partial products
  always_ff @(posedge clk) begin
    if (start) begin
      h <= key_sh ^ (key_sh >> FMIX_SHIFT);
    end else if (busy) begin
      unique case (step)
        3'd0: prod <= mul_full;
        3'd1: begin
          prod <= mul_full;
          acc  <= prod;
        end
        3'd2: begin
          prod <= mul_full;
          acc  <= acc + {prod[31:0], 32'd0};
        end
        3'd3: acc <= acc + {prod[31:0], 32'd0};
        3'd4: h <= acc ^ (acc >> FMIX_SHIFT);
        default: ;
      endcase
    end
  end

  assign hash = h;

endmodule

// ===== rtl/core/fhm_front.sv =====
module fhm_front #(
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            rst,
  fhm_req_if.sink         req,
  input  logic            init_done,
  output fhm_pkg::entry_t push_ent,
  output logic [AW-1:0]   push_home,
  output logic            push_valid,
  input  logic            push_ready
);
  import fhm_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]  state;
  entry_t      ent;
  logic [AW-1:0] home;
  logic        accept;
  logic        need_hash;
  logic        hash_done;
  logic [63:0] hash;

  assign req.ready = (state == F_IDLE) && init_done;
  assign accept    = req.valid && req.ready;
  assign need_hash = ((req.opcode == OP_LOOKUP) || (req.opcode == OP_INSERT))
                     && (req.key != 64'd0);

  fhm_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (accept && need_hash),
    .key   (req.key),
    .done  (hash_done),
    .hash  (hash)
  );

  // sequencer: accept, wait for hash when one is needed, hand over to queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (accept) state <= need_hash ? F_HASH : F_PUSH;
        F_HASH: if (hash_done) state <= F_PUSH;
        F_PUSH: if (push_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  // classify the accepted request; latch the home slot when the hash is done
  always_ff @(posedge clk) begin
    if (accept) begin
      ent.key    <= req.key;
      ent.value  <= req.new_value;
      unique case (req.opcode)
        OP_LOOKUP: begin
          ent.cmd <= need_hash ? CMD_LOOKUP : CMD_RESULT;
          ent.status <= need_hash ? ST_OK : ST_MISS;
        end
        OP_INSERT: begin
          ent.cmd <= need_hash ? CMD_INSERT : CMD_RESULT;
          ent.status <= need_hash ? ST_OK : ST_ZERO;
        end
        OP_CLEAR: begin
          ent.cmd    <= CMD_CLEAR;
          ent.status <= ST_OK;
        end
        default: begin
          ent.cmd    <= CMD_RESULT;
          ent.status <= ST_OK;
        end
      endcase
    end
    if (hash_done) home <= hash[AW-1:0];
  end

  assign push_ent   = ent;
  assign push_home  = home;
  assign push_valid = (state == F_PUSH);

endmodule

// ===== rtl/core/fhm_queue.sv =====
module fhm_queue #(
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  fhm_pkg::entry_t push_ent,
  input  logic [AW-1:0]   push_home,
  input  logic            push_valid,
  output logic            push_ready,
  output fhm_pkg::entry_t pop_ent,
  output logic [AW-1:0]   pop_home,
  output logic            pop_valid,
  input  logic            pop_ready
);
  import fhm_pkg::*;

  entry_t        ents  [2];
  logic [AW-1:0] homes [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop)      fill <= fill + 2'd1;
      else if (!do_push && do_pop) fill <= fill - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ents[wr_ptr]  <= push_ent;
      homes[wr_ptr] <= push_home;
    end
  end

  assign pop_ent  = ents[rd_ptr];
  assign pop_home = homes[rd_ptr];

endmodule

// ===== rtl/core/fhm_back.sv =====
module fhm_back #(
  parameter int SLOTS = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  fhm_pkg::entry_t q_ent,
  input  logic [AW-1:0]   q_home,
  input  logic            q_valid,
  output logic            q_ready,
  output logic            init_done,
  fhm_rsp_if.source       rsp
);
  import fhm_pkg::*;

  localparam logic [2:0] B_INIT  = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_PROBE = 3'd2;
  localparam logic [2:0] B_SWEEP = 3'd3;
  localparam logic [2:0] B_DONE  = 3'd4;

  // insert is refused once the count reaches this value
  localparam int FULL_AT = (SLOTS * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN - 1;

  logic [2:0]    state;
  logic [1:0]    cmd;
  logic [63:0]   key_r;
  logic [63:0]   value_r;
  logic [AW-1:0] chk_addr;
  logic [AW-1:0] sw_addr;
  logic [AW-1:0] count;
  logic [1:0]    pend_status;
  logic [63:0]   pend_value;

  logic          res_valid;
  logic [1:0]    res_status;
  logic [63:0]   res_value;
  logic          res_load;

  // slot memories
  logic          mem_valid [SLOTS];
  logic [63:0]   mem_key   [SLOTS];
  logic [63:0]   mem_value [SLOTS];
  logic          rd_valid;
  logic [63:0]   rd_key;
  logic [63:0]   rd_value;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          v_we;
  logic          kv_we;
  logic          slot_empty;
  logic          key_hit;
  logic          is_full;

  assign init_done  = (state != B_INIT);
  assign q_ready    = (state == B_IDLE);
  assign slot_empty = !rd_valid;
  assign key_hit    = rd_valid && (rd_key == key_r);
  assign is_full    = (count >= AW'(FULL_AT));
  assign res_load   = (state == B_DONE) && (!res_valid || rsp.ready);

  // memory addressing: probe reads one slot ahead of the slot being checked
  assign rd_addr = (state == B_PROBE) ? AW'(chk_addr + 1'b1) : q_home;
  assign wr_addr = (state == B_PROBE) ? chk_addr : sw_addr;
  assign kv_we   = (state == B_PROBE) && (cmd == CMD_INSERT) && slot_empty;
  assign v_we    = kv_we || (state == B_SWEEP) || (state == B_INIT);

  always_ff @(posedge clk) begin
    if (v_we) mem_valid[wr_addr] <= (state == B_PROBE);
    if (kv_we) begin
      mem_key[wr_addr]   <= key_r;
      mem_value[wr_addr] <= value_r;
    end
    rd_valid <= mem_valid[rd_addr];
    rd_key   <= mem_key[rd_addr];
    rd_value <= mem_value[rd_addr];
  end

  // back sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_INIT;
      sw_addr <= '0;
      count   <= '0;
    end else begin
      unique case (state)
        B_INIT: begin
          sw_addr <= AW'(sw_addr + 1'b1);
          if (&sw_addr) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid) begin
            unique case (q_ent.cmd)
              CMD_LOOKUP: state <= B_PROBE;
              CMD_INSERT: state <= is_full ? B_DONE : B_PROBE;
              CMD_CLEAR: begin
                count   <= '0;
                sw_addr <= '0;
                state   <= B_SWEEP;
              end
              default: state <= B_DONE;
            endcase
          end
        end
        B_PROBE: begin
          if (cmd == CMD_INSERT) begin
            if (slot_empty) begin
              count <= AW'(count + 1'b1);
              state <= B_DONE;
            end
          end else if (slot_empty || key_hit) begin
            state <= B_DONE;
          end
        end
        B_SWEEP: begin
          sw_addr <= AW'(sw_addr + 1'b1);
          if (&sw_addr) state <= B_DONE;
        end
        B_DONE: if (res_load) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // working registers and pending result
  always_ff @(posedge clk) begin
    if ((state == B_IDLE) && q_valid) begin
      cmd         <= q_ent.cmd;
      key_r       <= q_ent.key;
      value_r     <= q_ent.value;
      chk_addr    <= q_home;
      pend_value  <= 64'd0;
      pend_status <= ((q_ent.cmd == CMD_INSERT) && is_full) ? ST_FULL : q_ent.status;
    end else if (state == B_PROBE) begin
      if (cmd == CMD_INSERT) begin
        pend_status <= ST_OK;
      end else if (key_hit) begin
        pend_status <= ST_OK;
        pend_value  <= rd_value;
      end else if (slot_empty) begin
        pend_status <= ST_MISS;
      end
      chk_addr <= AW'(chk_addr + 1'b1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= pend_status;
      res_value  <= pend_value;
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.found_value = res_value;

endmodule
